FILE: sv/quaternion_to_rotation_matrix_core_macros.svh
// Assertion macros for the quaternion to rotation matrix core.
// Included by the top level; depends on nothing else.
`ifndef QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define Q2M_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define Q2M_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: sv/q2m_pkg.sv
// Package for the quaternion to rotation matrix core: payload types and constants.
// Depends on nothing.
`default_nettype none
package q2m_pkg;
   localparam int DW = 16;
   localparam int FB = DW - 1;
   localparam int PW = 2 * DW;      // product width
   localparam int NW = 2 * DW + 1;  // norm width (sum of four squares)
   localparam int NDIV = FB + 2;    // quotient field top index (q is NDIV+1 bits wide)

   typedef struct packed {
      logic signed [DW-1:0] q_w;
      logic signed [DW-1:0] q_x;
      logic signed [DW-1:0] q_y;
      logic signed [DW-1:0] q_z;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] m00;
      logic signed [DW-1:0] m01;
      logic signed [DW-1:0] m02;
      logic signed [DW-1:0] m10;
      logic signed [DW-1:0] m11;
      logic signed [DW-1:0] m12;
      logic signed [DW-1:0] m20;
      logic signed [DW-1:0] m21;
      logic signed [DW-1:0] m22;
      logic                 degenerate;
   } rsp_type;

   // Element state carried through the divider stages.
   typedef struct packed {
      logic          neg;
      logic [NW:0]   r;
      logic [NDIV:0] q;
   } div_type;
endpackage
`default_nettype wire

FILE: sv/q2m_div_stage.sv
// One restoring-division step for nine elements, registered.
// Depends on q2m_pkg.
`default_nettype none
module q2m_div_stage import q2m_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          vld_in,
   input  wire logic [NW-1:0] n_in,
   input  wire logic          deg_in,
   input  wire div_type       el_in [9],
   output logic               vld_out,
   output logic [NW-1:0]      n_out,
   output logic               deg_out,
   output div_type            el_out [9]
);
   logic          vld_ff;
   logic [NW-1:0] n_ff;
   logic          deg_ff;
   div_type       el_ff [9];
   div_type       el_in_n [9];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         logic [NW:0] nr;
         nr = {1'b0, n_in} - el_in[i].r;
         el_in_n[i].neg = el_in[i].neg;
         // r >= n - r
         if (el_in[i].r >= nr) begin
            el_in_n[i].r = el_in[i].r - nr;
            el_in_n[i].q = {el_in[i].q[NDIV-1:0], 1'b1};
         end else begin
            el_in_n[i].r = el_in[i].r + el_in[i].r;
            el_in_n[i].q = {el_in[i].q[NDIV-1:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      n_ff   <= n_in;
      deg_ff <= deg_in;
      el_ff  <= el_in_n;
   end

   assign vld_out = vld_ff;
   assign n_out   = n_ff;
   assign deg_out = deg_ff;
   assign el_out  = el_ff;
endmodule
`default_nettype wire

FILE: sv/quaternion_to_rotation_matrix_core.sv
// Top level of the quaternion to rotation matrix core.
// Depends on q2m_pkg, q2m_div_stage and the assertion macro header.
//
// Usage: drive req_data and pulse start; a transfer happens when start is high
// and busy is low. Busy is tied low: one quaternion may enter every cycle.
// Each transfer yields exactly one result on rsp_data, marked by rsp_valid
// for one cycle; the receiver cannot stall, so results are never held.
// Pipeline: stage 1 saturates inputs and forms ten products, stage 2 forms
// the norm and element numerators, stage 3 takes magnitudes, clamps and sets
// the integer quotient bit, then FB stages each produce one fraction bit
// (restoring division against the norm), then a final stage rounds,
// saturates and substitutes the identity for a zero quaternion.
// Throughput is one item per cycle.
// The fraction-bit chain of the divider sets the latency.
// Reset clears only the valid bits; payload registers are not reset.
// A zero quaternion yields the identity (diagonal 2^F-1) with degenerate set.
`default_nettype none
`include "quaternion_to_rotation_matrix_core_macros.svh"
module quaternion_to_rotation_matrix_core import q2m_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   // ---- stage 1: saturate and multiply
   logic signed [DW-1:0] w_s, x_s, y_s, z_s;
   logic                 v1_ff;
   logic signed [PW-1:0] w2_ff, x2_ff, y2_ff, z2_ff;
   logic signed [PW-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;

   function automatic logic signed [DW-1:0] sat_in(input logic signed [DW-1:0] v);
      logic signed [DW-1:0] mn;
      mn = {1'b1, {(DW-1){1'b0}}};
      return (v == mn) ? mn + DW'(1) : v;
   endfunction

   assign busy = 1'b0;
   assign w_s = sat_in(req_data.q_w);
   assign x_s = sat_in(req_data.q_x);
   assign y_s = sat_in(req_data.q_y);
   assign z_s = sat_in(req_data.q_z);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      w2_ff <= w_s * w_s;
      x2_ff <= x_s * x_s;
      y2_ff <= y_s * y_s;
      z2_ff <= z_s * z_s;
      xy_ff <= x_s * y_s;
      wz_ff <= w_s * z_s;
      xz_ff <= x_s * z_s;
      wy_ff <= w_s * y_s;
      yz_ff <= y_s * z_s;
      wx_ff <= w_s * x_s;
   end

   // ---- stage 2: norm and numerators (diagonal as-is, off-diagonal doubled)
   localparam int SW = NW + 2;
   logic                 v2_ff;
   logic [NW-1:0]        n2_ff;
   logic signed [SW-1:0] num_ff [9];

   function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] v);
      return SW'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      n2_ff     <= NW'(ext(w2_ff) + ext(x2_ff) + ext(y2_ff) + ext(z2_ff));
      num_ff[0] <= (ext(w2_ff) + ext(x2_ff)) - (ext(y2_ff) + ext(z2_ff));
      num_ff[1] <= (ext(xy_ff) - ext(wz_ff)) <<< 1;
      num_ff[2] <= (ext(xz_ff) + ext(wy_ff)) <<< 1;
      num_ff[3] <= (ext(xy_ff) + ext(wz_ff)) <<< 1;
      num_ff[4] <= (ext(w2_ff) + ext(y2_ff)) - (ext(x2_ff) + ext(z2_ff));
      num_ff[5] <= (ext(yz_ff) - ext(wx_ff)) <<< 1;
      num_ff[6] <= (ext(xz_ff) - ext(wy_ff)) <<< 1;
      num_ff[7] <= (ext(yz_ff) + ext(wx_ff)) <<< 1;
      num_ff[8] <= (ext(w2_ff) + ext(z2_ff)) - (ext(x2_ff) + ext(y2_ff));
   end

   // ---- stage 3: magnitude, clamp to n, integer bit
   logic          v3_ff;
   logic [NW-1:0] n3_ff;
   logic          deg3_ff;
   div_type       el3_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      n3_ff   <= n2_ff;
      deg3_ff <= (n2_ff == '0);
      for (int i = 0; i < 9; i++) begin
         logic [SW-1:0] mag;
         logic [NW:0]   m;
         mag = num_ff[i][SW-1] ? SW'(-num_ff[i]) : SW'(num_ff[i]);
         m   = (mag > SW'(n2_ff)) ? {1'b0, n2_ff} : (NW+1)'(mag);
         el3_ff[i].neg <= num_ff[i][SW-1];
         if (m >= {1'b0, n2_ff}) begin
            el3_ff[i].r <= m - {1'b0, n2_ff};
            el3_ff[i].q <= (NDIV+1)'(1);
         end else begin
            el3_ff[i].r <= m;
            el3_ff[i].q <= '0;
         end
      end
   end

   // ---- divider chain: one fraction bit per stage
   logic          dv  [FB+1];
   logic [NW-1:0] dn  [FB+1];
   logic          ddg [FB+1];
   div_type       del [FB+1][9];

   assign dv[0]  = v3_ff;
   assign dn[0]  = n3_ff;
   assign ddg[0] = deg3_ff;
   assign del[0] = el3_ff;

   for (genvar g = 0; g < FB; g++) begin : g_div
      q2m_div_stage u_stage (
         .clock   (clock),
         .reset   (reset),
         .vld_in  (dv[g]),
         .n_in    (dn[g]),
         .deg_in  (ddg[g]),
         .el_in   (del[g]),
         .vld_out (dv[g+1]),
         .n_out   (dn[g+1]),
         .deg_out (ddg[g+1]),
         .el_out  (del[g+1])
      );
   end

   // ---- final stage: round, sign, saturate, identity
   localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
   logic    vo_ff;
   rsp_type ro_ff;
   logic [DW-1:0] res [9];

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         logic [NW:0]   nr;
         logic [NDIV:0] q;
         logic [DW:0]   qs;
         nr = {1'b0, dn[FB]} - del[FB][i].r;
         q  = del[FB][i].q + ((del[FB][i].r >= nr) ? (NDIV+1)'(1) : '0);
         qs = (DW+1)'(q);
         if (del[FB][i].neg) begin
            res[i] = DW'(-qs);
         end else if (qs > (DW+1)'((1 << FB) - 1)) begin
            res[i] = DW'((1 << FB) - 1);
         end else begin
            res[i] = DW'(qs);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= dv[FB];
      end
      // Substitute the identity for a zero quaternion.
      if (ddg[FB]) begin
         ro_ff <= {MAXP, {(3*DW){1'b0}}, MAXP, {(3*DW){1'b0}}, MAXP, 1'b1};
      end else begin
         ro_ff <= {res[0], res[1], res[2], res[3], res[4], res[5], res[6], res[7],
                   res[8], 1'b0};
      end
   end

   assign rsp_valid = vo_ff;
   assign rsp_data  = ro_ff;

   // ---- assertions
   `Q2M_ASSERT_IMP(a_busy_low, clock, reset, 1'b1, !busy, "busy must stay low")
   `Q2M_ASSERT_IMP(a_deg_ident, clock, reset, rsp_valid && rsp_data.degenerate,
      rsp_data.m00 == DW'((1 << FB) - 1) && rsp_data.m01 == '0,
      "degenerate result is not identity")
   `Q2M_ASSERT_NEXT(a_stage3, clock, reset, v2_ff, v3_ff,
      "valid lost between stages")
endmodule
`default_nettype wire
